[rtl/yld_pkg.sv]
// yld_pkg: widths, register map and reset values for the luma 2x2 downscaler
// no dependencies; imported by yuv422_luma_2x2_downscale_core
package yld_pkg;

   localparam int LUMA_W     = 8;
   localparam int SUM_W      = 9;
   localparam int TOTAL_W    = 10;
   localparam int UNITS_W    = 8;
   localparam int HEIGHT_W   = 12;
   localparam int ROW_W      = 11;
   localparam int PAIR_W     = 11;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [UNITS_W-1:0]  UNITS_RESET  = 8'd40;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 12'd2;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 12'd2048;

   typedef enum logic {
      REG_WIDTH_UNITS  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [SUM_W-1:0] pair_sum;
      logic             frame_end;
   } stage_type;

endpackage

[rtl/yuv422_luma_2x2_downscale_core.sv]
// yuv422_luma_2x2_downscale_core: top level of the UYVY luma 2x2 box downscaler
// depends on yld_pkg and yld_ram
//
// Takes one UYVY pixel pair (two luma bytes) per request in raster order and
// returns a half-width, half-height luma image, each byte the truncated mean of
// a 2x2 block. A request can be accepted every cycle, with no bubbles, unless a
// stalled result holds the stage; even-row requests only write their pair sum
// into the line buffer and return nothing, odd-row requests return one byte
// through the stage register and the result register. The line buffer is one
// ram of MAX_WIDTH/2 entries by 9 bits with a registered read; it needs no clearing pass after reset.
// Width is set in 16-pixel units (zero reads as one pair, large values clamp to
// MAX_WIDTH), height in rows clamped to 2..2048, and an odd last row is dropped.
module yuv422_luma_2x2_downscale_core
   import yld_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [LUMA_W-1:0]     req_luma_even,
   input  logic [LUMA_W-1:0]     req_luma_odd,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [LUMA_W-1:0]     rsp_shrunk_luma,
   output logic                  rsp_frame_end,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int COL_W      = $clog2(LINE_DEPTH);
   localparam int CMP_W      = (COL_W + 1 > PAIR_W) ? COL_W + 1 : PAIR_W;

   logic [UNITS_W-1:0]  width_units_ff, width_units_in;
   logic [HEIGHT_W-1:0] frame_height_ff, frame_height_in;
   logic [COL_W-1:0]    column_count_ff, column_count_in;
   logic [ROW_W-1:0]    row_count_ff, row_count_in;
   logic                stage_valid_ff, stage_valid_in;
   stage_type           stage_ff, stage_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LUMA_W-1:0]   rsp_luma_ff, rsp_luma_in;
   logic                rsp_end_ff, rsp_end_in;

   logic                csr_write;
   reg_index_type       csr_index;
   logic                accept;
   logic                odd_row;
   logic                stage_advance;
   logic                row_end;
   logic                frame_end;
   logic [CMP_W-1:0]    unit_pairs;
   logic [CMP_W-1:0]    pairs;
   logic [HEIGHT_W-1:0] rows;
   logic [HEIGHT_W-1:0] last_out_row;
   logic [HEIGHT_W-1:0] next_row;
   logic [SUM_W-1:0]    pair_sum;
   logic [SUM_W-1:0]    line_sum;
   logic [TOTAL_W-1:0]  block_total;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_units_in  = width_units_ff;
      frame_height_in = frame_height_ff;
      csr_prdata      = '0;
      case (csr_index)
         REG_WIDTH_UNITS: begin
            csr_prdata = CSR_DATA_W'(width_units_ff);
            if (csr_write) begin
               width_units_in = csr_pwdata[UNITS_W-1:0];
            end
         end
         REG_FRAME_HEIGHT: begin
            csr_prdata = CSR_DATA_W'(frame_height_ff);
            if (csr_write) begin
               frame_height_in = csr_pwdata[HEIGHT_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // row and frame geometry
   always_comb begin
      unit_pairs = CMP_W'({width_units_ff, 3'b000});
      pairs      = unit_pairs;
      if (unit_pairs == '0) begin
         pairs = CMP_W'(1);
      end else if (unit_pairs > CMP_W'(LINE_DEPTH)) begin
         pairs = CMP_W'(LINE_DEPTH);
      end
      rows = frame_height_ff;
      if (frame_height_ff < HEIGHT_MIN) begin
         rows = HEIGHT_MIN;
      end else if (frame_height_ff > HEIGHT_MAX) begin
         rows = HEIGHT_MAX;
      end
   end

   assign last_out_row = {rows[HEIGHT_W-1:1], 1'b0} - HEIGHT_W'(1);
   assign next_row     = HEIGHT_W'(row_count_ff) + HEIGHT_W'(1);
   assign row_end      = (CMP_W'(column_count_ff) + CMP_W'(1)) >= pairs;
   assign frame_end    = row_end && (HEIGHT_W'(row_count_ff) >= last_out_row);
   assign odd_row      = row_count_ff[0];

   // handshake
   assign stage_advance = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready     = !stage_valid_ff || stage_advance;
   assign accept        = req_valid && req_ready;

   assign pair_sum = SUM_W'(req_luma_even) + SUM_W'(req_luma_odd);

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept) begin
         if (row_end) begin
            column_count_in = '0;
            if (next_row >= rows) begin
               row_count_in = '0;
            end else begin
               row_count_in = next_row[ROW_W-1:0];
            end
         end else begin
            column_count_in = column_count_ff + COL_W'(1);
         end
      end
   end

   // line buffer of pair sums
   yld_ram #(
      .WIDTH (SUM_W),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (accept && !odd_row),
      .wr_addr (column_count_ff),
      .wr_data (pair_sum),
      .rd_en   (accept && odd_row),
      .rd_addr (column_count_ff),
      .rd_data (line_sum)
   );

   // stage waiting on the ram read, then the result register
   always_comb begin
      stage_valid_in = stage_valid_ff && !stage_advance;
      stage_in       = stage_ff;
      if (accept && odd_row) begin
         stage_valid_in     = 1'b1;
         stage_in.pair_sum  = pair_sum;
         stage_in.frame_end = frame_end;
      end
   end

   assign block_total = TOTAL_W'(line_sum) + TOTAL_W'(stage_ff.pair_sum);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_luma_in  = rsp_luma_ff;
      rsp_end_in   = rsp_end_ff;
      if (stage_advance) begin
         rsp_valid_in = 1'b1;
         rsp_luma_in  = block_total[TOTAL_W-1:2];
         rsp_end_in   = stage_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_units_ff  <= UNITS_RESET;
         frame_height_ff <= HEIGHT_RESET;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         stage_valid_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         width_units_ff  <= width_units_in;
         frame_height_ff <= frame_height_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         stage_valid_ff  <= stage_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff    <= stage_in;
      rsp_luma_ff <= rsp_luma_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_shrunk_luma = rsp_luma_ff;
   assign rsp_frame_end   = rsp_end_ff;

   // checks
   odd_request_staged: assert property (@(posedge clock) disable iff (reset)
      accept && odd_row |=> stage_valid_ff)
      else $error("odd-row request not staged");

   row_end_wraps_column: assert property (@(posedge clock) disable iff (reset)
      accept && row_end |=> column_count_ff == '0)
      else $error("column count did not wrap at row end");

   stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !stage_advance |=> stage_valid_ff && $stable(stage_ff))
      else $error("stage lost while result register stalled");

   frame_end_only_at_row_end: assert property (@(posedge clock) disable iff (reset)
      accept && odd_row && !row_end |=> !stage_ff.frame_end)
      else $error("frame end flagged before the end of a row");

endmodule

[rtl/yld_ram.sv]
// yld_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies; used for the pair-sum line buffer
module yld_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[verif/yuv422_luma_2x2_downscale_core_tb.sv]
// yuv422_luma_2x2_downscale_core_tb: self-checking bench for the luma 2x2 box downscaler;
// drives pixel-pair requests and csr writes, predicts each shrunk byte and compares results
// depends on yld_pkg and yuv422_luma_2x2_downscale_core
module yuv422_luma_2x2_downscale_core_tb;
   import yld_pkg::*;

   localparam int LINE_DEPTH = 1024;

   typedef struct packed {
      logic [LUMA_W-1:0] luma;
      logic              frame_end;
   } shrunk_pixel_type;

   typedef struct {
      bit                  reconfig;
      logic [UNITS_W-1:0]  units;
      logic [HEIGHT_W-1:0] height;
      logic [LUMA_W-1:0]   even_y;
      logic [LUMA_W-1:0]   odd_y;
      bit                  typed;
      logic [LUMA_W-1:0]   want_luma;
      bit                  want_end;
   } directed_row_type;

   typedef struct {
      int units;
      int height;
      int count;
      int send_idle;
      int recv_stall;
      bit hold;
      bit frame_start;
   } geometry_phase_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [LUMA_W-1:0]     req_luma_even;
   logic [LUMA_W-1:0]     req_luma_odd;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [LUMA_W-1:0]     rsp_shrunk_luma;
   logic                  rsp_frame_end;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   yuv422_luma_2x2_downscale_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_luma_even   (req_luma_even),
      .req_luma_odd    (req_luma_odd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_shrunk_luma (rsp_shrunk_luma),
      .rsp_frame_end   (rsp_frame_end),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // predictor state
   logic [SUM_W-1:0]    line_sums [0:LINE_DEPTH-1];
   logic [UNITS_W-1:0]  units_reg;
   logic [HEIGHT_W-1:0] height_reg;
   int unsigned         col_idx;
   int unsigned         row_idx;

   shrunk_pixel_type pending_pixels [$];
   int               mismatch_count;
   int               send_idle;
   int               recv_stall;

   directed_row_type directed_rows [28] = '{
      '{1, 0, 0, 255, 255, 0, 0, 0},
      '{0, 0, 0, 255, 255, 1, 255, 1},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 1, 0, 1},
      '{0, 0, 0, 255, 0, 0, 0, 0},
      '{0, 0, 0, 0, 255, 1, 127, 1},
      // odd height: third row consumed with no result
      '{1, 0, 3, 10, 20, 0, 0, 0},
      '{0, 0, 0, 30, 40, 1, 25, 1},
      '{0, 0, 0, 200, 100, 0, 0, 0},
      '{0, 0, 0, 5, 5, 0, 0, 0},
      '{0, 0, 0, 5, 5, 1, 5, 1},
      '{0, 0, 0, 7, 9, 0, 0, 0},
      // narrowest nonzero width, height below minimum
      '{1, 1, 1, 255, 0, 0, 0, 0},
      '{0, 0, 0, 0, 255, 0, 0, 0},
      '{0, 0, 0, 128, 127, 0, 0, 0},
      '{0, 0, 0, 1, 1, 0, 0, 0},
      '{0, 0, 0, 254, 254, 0, 0, 0},
      '{0, 0, 0, 85, 170, 0, 0, 0},
      '{0, 0, 0, 170, 85, 0, 0, 0},
      '{0, 0, 0, 127, 128, 0, 0, 0},
      '{0, 0, 0, 255, 255, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 64, 64, 0, 0, 0},
      '{0, 0, 0, 1, 0, 0, 0, 0},
      '{0, 0, 0, 255, 255, 0, 0, 0},
      '{0, 0, 0, 100, 50, 0, 0, 0},
      '{0, 0, 0, 0, 1, 0, 0, 0},
      '{0, 0, 0, 255, 255, 0, 0, 0}
   };

   geometry_phase_type phases [8] = '{
      '{2, 4, 80, 0, 0, 1, 0},
      '{1, 2, 80, 65, 0, 0, 0},
      '{3, 5, 80, 0, 65, 0, 0},
      '{0, 4095, 60, 38, 38, 0, 0},
      '{255, 1, 160, 38, 38, 0, 1},
      '{128, 2, 40, 0, 0, 0, 0},
      '{4, 2048, 80, 65, 0, 0, 0},
      '{2, 3, 80, 0, 65, 0, 0}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 600_000);
      $display("FAILED: results differ");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall);
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < 30)
         $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      shrunk_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_shrunk_luma, -1);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_shrunk_luma !== want.luma)
               report_mismatch("shrunk_luma", rsp_shrunk_luma, want.luma);
            if (rsp_frame_end !== want.frame_end)
               report_mismatch("frame_end", rsp_frame_end, want.frame_end);
         end
      end
   end

   function automatic int unsigned pairs_for(input logic [UNITS_W-1:0] u);
      int unsigned p;
      p = u;
      p = p * 8;
      if (p == 0) p = 1;
      if (p > LINE_DEPTH) p = LINE_DEPTH;
      return p;
   endfunction

   function automatic logic [LUMA_W-1:0] rand_luma();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic shrink_pair(input logic [LUMA_W-1:0] ev, input logic [LUMA_W-1:0] od,
                              output bit has, output shrunk_pixel_type px);
      int unsigned       pairs;
      int unsigned       rows;
      int unsigned       last_row;
      logic [TOTAL_W-1:0] sum;
      logic [TOTAL_W-1:0] total;
      bit                row_end;
      pairs = pairs_for(units_reg);
      rows = height_reg;
      if (rows < HEIGHT_MIN) rows = HEIGHT_MIN;
      if (rows > HEIGHT_MAX) rows = HEIGHT_MAX;
      last_row = (rows & ~32'd1) - 1;
      sum = TOTAL_W'(ev) + TOTAL_W'(od);
      row_end = (col_idx + 1 >= pairs);
      has = 1'b0;
      px = '0;
      if (!row_idx[0]) begin
         line_sums[col_idx] = sum[SUM_W-1:0];
      end else begin
         total = TOTAL_W'(line_sums[col_idx]) + sum;
         px.luma = total[TOTAL_W-1:2];
         px.frame_end = row_end && (row_idx >= last_row);
         has = 1'b1;
      end
      if (row_end) begin
         col_idx = 0;
         row_idx = (row_idx + 1 >= rows) ? 0 : row_idx + 1;
      end else begin
         col_idx = col_idx + 1;
      end
   endtask

   task automatic send_pair(input logic [LUMA_W-1:0] ev, input logic [LUMA_W-1:0] od,
                            input bit typed, input shrunk_pixel_type typed_px);
      bit               has;
      shrunk_pixel_type px;
      while ($urandom_range(99) < send_idle) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_luma_even <= ev;
      req_luma_odd  <= od;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shrink_pair(ev, od, has, px);
      if (typed)
         pending_pixels.push_back(typed_px);
      else if (has)
         pending_pixels.push_back(px);
   endtask

   // drop valid, let every pending byte come back, then let the line buffer write settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_read(input reg_index_type idx, output logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_write(input reg_index_type idx, input int value);
      logic [CSR_DATA_W-1:0] word;
      logic [CSR_DATA_W-1:0] readback;
      int                    reg_w;
      reg_w = (idx == REG_WIDTH_UNITS) ? UNITS_W : HEIGHT_W;
      // junk above the register width must be ignored
      word = ($urandom() << reg_w) | (value & ((1 << reg_w) - 1));
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == REG_WIDTH_UNITS)
         units_reg = word[UNITS_W-1:0];
      else
         height_reg = word[HEIGHT_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_read(idx, readback);
      if (readback !== (word & ((1 << reg_w) - 1)))
         report_mismatch("register readback", readback, word & ((1 << reg_w) - 1));
   endtask

   // a wider row must never read line entries that no even row has filled
   task automatic set_geometry(input int units, input int height, input bit frame_start);
      wait_idle();
      csr_write(REG_FRAME_HEIGHT, height);
      if (frame_start ||
          (pairs_for(UNITS_W'(units)) > pairs_for(units_reg) && row_idx[0])) begin
         while (frame_start ? (row_idx != 0 || col_idx != 0) : row_idx[0])
            send_pair(rand_luma(), rand_luma(), 1'b0, '0);
         wait_idle();
      end
      csr_write(REG_WIDTH_UNITS, units);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] rd;
      shrunk_pixel_type      typed_px;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_luma_even  = '0;
      req_luma_odd   = '0;
      rsp_ready      = 1'b1;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      send_idle      = 0;
      recv_stall     = 0;
      mismatch_count = 0;
      units_reg      = UNITS_RESET;
      height_reg     = HEIGHT_RESET;
      col_idx        = 0;
      row_idx        = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_read(REG_WIDTH_UNITS, rd);
      if (rd !== CSR_DATA_W'(UNITS_RESET))
         report_mismatch("width_units after reset", rd, UNITS_RESET);
      csr_read(REG_FRAME_HEIGHT, rd);
      if (rd !== CSR_DATA_W'(HEIGHT_RESET))
         report_mismatch("frame_height after reset", rd, HEIGHT_RESET);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].reconfig)
            set_geometry(directed_rows[i].units, directed_rows[i].height, 1'b0);
         typed_px.luma      = directed_rows[i].want_luma;
         typed_px.frame_end = directed_rows[i].want_end;
         send_pair(directed_rows[i].even_y, directed_rows[i].odd_y,
                   directed_rows[i].typed, typed_px);
      end

      foreach (phases[p]) begin
         send_idle  = phases[p].send_idle;
         recv_stall = phases[p].recv_stall;
         set_geometry(phases[p].units, phases[p].height, phases[p].frame_start);
         for (int i = 0; i < phases[p].count; i++) begin
            if (phases[p].hold && i == phases[p].count / 2)
               wait_idle();
            send_pair(rand_luma(), rand_luma(), 1'b0, '0);
         end
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

[files.f]
rtl/yld_pkg.sv
rtl/yld_ram.sv
rtl/yuv422_luma_2x2_downscale_core.sv
verif/yuv422_luma_2x2_downscale_core_tb.sv
